>>> sv/gffgc_pkg.sv
// shared constants and types for the greedy first-fit graph coloring block
`timescale 1ns / 1ps

package gffgc_pkg;

    // default sizes of the color table and the palette
    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_MAX_COLORS   = 256;

    // request and result field widths
    localparam int VID_W      = 12;
    localparam int OCOLOR_W   = 8;
    localparam int OCOUNT_W   = 9;
    localparam int S_TDATA_W  = 2 * VID_W;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;
    localparam int M_PAD_W    = M_TDATA_W - VID_W - OCOLOR_W - OCOUNT_W;

    // bit positions of the request flags in tuser
    localparam int USER_HAS = 0;
    localparam int USER_NEW = 1;

    // graph generation tag kept with every stored color
    localparam int EPOCH_W = 6;

    typedef logic [VID_W-1:0]   vid_t;
    typedef logic [EPOCH_W-1:0] epoch_t;

    localparam epoch_t EPOCH_MAX = '1;

endpackage

>>> sv/greedy_first_fit_graph_coloring.sv
// greedy first-fit graph coloring: color table in ram, streamed adjacency rows
//
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tdata: vertex_id, neighbor_id; tuser: flags; tlast
//  m_axis    out  tvalid/tready        tdata: vertex, color, count; tuser: overflow
//
// one request per cycle; a request whose neighbor is the vertex closed by one of the
// two requests just before it waits until that color has been decided
// a request travels read, search, decide; a closing request's result then goes to m_axis
// after reset every entry of the color ram is swept clear with s_axis_tready low;
// the same sweep runs before a new-graph request when the epoch is at EPOCH_MAX (wrap)
// a stalled m_axis holds the whole pipeline, and s_axis_tready, only while the result
// register is full and the decide stage holds a closing request
`timescale 1ns / 1ps

module greedy_first_fit_graph_coloring
    import gffgc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_COLORS   = DEF_MAX_COLORS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [11:0] vertex_id, [23:12] neighbor_id
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] has_neighbor, [1] new_graph
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [11:0] colored_vertex, [19:12] assigned_color, [28:20] colors_used, zero above
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] palette_overflow
    output logic                 m_axis_tuser
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int LW    = $clog2(MAX_COLORS);
    localparam int CNT_W = $clog2(MAX_COLORS + 1);
    localparam int GL    = (LW + 1) / 2;
    localparam int G     = 1 << GL;
    localparam int NG    = 1 << (LW - GL);
    localparam int P     = 1 << LW;
    localparam int MEM_W = 1 + EPOCH_W + LW;

    typedef logic [MAX_COLORS-1:0] cmask_t;
    typedef logic [P-1:0]          pmask_t;

    typedef struct packed {
        vid_t   vertex;
        logic   stored;
        logic   last;
        logic   fresh;
        epoch_t epoch;
    } item_t;

    typedef enum logic {ST_SWEEP, ST_RUN} state_t;

    state_t           state_reg;
    logic [AW-1:0]    sweep_addr_reg;

    // request decode
    vid_t             in_vertex;
    vid_t             in_nb;
    logic             in_has;
    logic             in_fresh;
    epoch_t           in_epoch;
    logic             accept;
    logic             conflict;
    logic             need_wrap;
    logic             pipe_empty;
    logic             adv;

    // pipeline registers
    logic             b_v_reg, c_v_reg, d_v_reg;
    item_t            b_reg, c_reg, d_reg;
    vid_t             b_nb_reg;
    logic             b_nb_ok_reg;
    pmask_t           c_mask_reg;
    logic [NG-1:0]    d_free_reg;
    logic [GL-1:0]    d_off_reg [NG];

    epoch_t           epoch_reg;
    logic [CNT_W-1:0] count_reg;
    cmask_t           mask_reg;

    // last write, seen by the request read in the same cycle
    logic             lw_v_reg;
    vid_t             lw_vertex_reg;
    epoch_t           lw_epoch_reg;
    logic [LW-1:0]    lw_color_reg;

    // result register
    logic             out_v_reg;
    vid_t             out_vertex_reg;
    logic [LW-1:0]    out_color_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_ovf_reg;

    // ram ports
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [MEM_W-1:0] ram_wdata;
    logic [MEM_W-1:0] ram_rdata;

    // read stage signals
    logic             rd_valid;
    epoch_t           rd_epoch;
    logic [LW-1:0]    rd_color;
    logic             fwd_hit;
    logic             nb_colored;
    logic [LW-1:0]    nb_color;
    cmask_t           mask_base;
    cmask_t           mask_eff;
    pmask_t           fin_mask;

    // search stage signals
    logic [NG-1:0]    c_free;
    logic [GL-1:0]    c_off [NG];

    // decide stage signals
    logic             d_found;
    logic [LW-1:0]    d_first;
    logic [CNT_W-1:0] count_base;
    logic [CNT_W-1:0] d_count_new;
    logic [LW-1:0]    d_color;
    logic             d_ovf;
    logic             d_wr;
    logic             out_load;

    // request fields
    assign in_vertex = s_axis_tdata[VID_W-1:0];
    assign in_nb     = s_axis_tdata[2*VID_W-1:VID_W];
    assign in_has    = s_axis_tuser[USER_HAS];
    assign in_fresh  = s_axis_tuser[USER_NEW];
    assign in_epoch  = in_fresh ? epoch_t'(epoch_reg + 1'b1) : epoch_reg;

    // flow control: decide stage holds only when its result has nowhere to go
    assign adv        = !(d_v_reg && d_reg.last && out_v_reg && !m_axis_tready);
    assign conflict   = in_has &&
                        ((b_v_reg && b_reg.last && b_reg.vertex == in_nb) ||
                         (c_v_reg && c_reg.last && c_reg.vertex == in_nb));
    assign need_wrap  = in_fresh && (epoch_reg == EPOCH_MAX);
    assign pipe_empty = !b_v_reg && !c_v_reg && !d_v_reg;

    assign s_axis_tready = (state_reg == ST_RUN) && adv && !conflict && !need_wrap;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // sweep sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_SWEEP:
                begin
                    sweep_addr_reg <= sweep_addr_reg + 1'b1;
                    if (sweep_addr_reg == AW'(MAX_VERTICES - 1))
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (s_axis_tvalid && need_wrap && pipe_empty)
                    begin
                        state_reg      <= ST_SWEEP;
                        sweep_addr_reg <= '0;
                    end
                end
                default:
                begin
                    state_reg <= ST_SWEEP;
                end
            endcase
        end
    end

    // read stage: stored color of the neighbor, newest write forwarded
    assign rd_valid   = ram_rdata[MEM_W-1];
    assign rd_epoch   = ram_rdata[MEM_W-2 -: EPOCH_W];
    assign rd_color   = ram_rdata[LW-1:0];
    assign fwd_hit    = lw_v_reg && lw_vertex_reg == b_nb_reg && lw_epoch_reg == b_reg.epoch;
    assign nb_color   = fwd_hit ? lw_color_reg : rd_color;
    assign nb_colored = b_nb_ok_reg && (fwd_hit || (rd_valid && rd_epoch == b_reg.epoch));
    assign mask_base  = b_reg.fresh ? '0 : mask_reg;
    assign mask_eff   = mask_base | (nb_colored ? (cmask_t'(1) << nb_color) : '0);
    assign fin_mask   = ({P{1'b1}} << MAX_COLORS) | pmask_t'(mask_eff);

    // search stage: first free color in each group
    always_comb
    begin
        logic [G-1:0] grp;
        grp = '0;
        for (int g = 0; g < NG; g++)
        begin
            grp       = c_mask_reg[g*G +: G];
            c_free[g] = ~&grp;
            c_off[g]  = '0;
            for (int i = G - 1; i >= 0; i--)
            begin
                if (!grp[i])
                begin
                    c_off[g] = GL'(i);
                end
            end
        end
    end

    // decide stage: first free group, then reuse, new color or saturate
    always_comb
    begin
        d_found = 1'b0;
        d_first = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (d_free_reg[g])
            begin
                d_found = 1'b1;
                d_first = LW'(g * G + int'(d_off_reg[g]));
            end
        end
        count_base  = d_reg.fresh ? '0 : count_reg;
        d_count_new = count_base;
        d_ovf       = 1'b0;
        if (d_found && CNT_W'(d_first) < count_base)
        begin
            d_color = d_first;
        end
        else if (count_base < CNT_W'(MAX_COLORS))
        begin
            d_color     = LW'(count_base);
            d_count_new = count_base + CNT_W'(1);
        end
        else
        begin
            d_color = LW'(MAX_COLORS - 1);
            d_ovf   = 1'b1;
        end
    end

    assign out_load = adv && d_v_reg && d_reg.last;
    assign d_wr     = out_load && d_reg.stored;

    // ram write port: sweep clears entries, otherwise the decided color
    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = d_wr;
            ram_waddr = AW'(d_reg.vertex);
            ram_wdata = {1'b1, d_reg.epoch, d_color};
        end
    end

    gffgc_ram
    #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_VERTICES)
    )
    u_color_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (AW'(in_nb)),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            lw_v_reg  <= 1'b0;
            epoch_reg <= '0;
            count_reg <= '0;
            mask_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                b_v_reg  <= accept;
                c_v_reg  <= b_v_reg;
                d_v_reg  <= c_v_reg;
                lw_v_reg <= d_wr;
                if (b_v_reg)
                begin
                    mask_reg <= b_reg.last ? '0 : mask_eff;
                end
                if (d_v_reg)
                begin
                    count_reg <= d_reg.last ? d_count_new : count_base;
                end
            end
            // a cleared ram restarts the generation count
            if (state_reg == ST_SWEEP)
            begin
                epoch_reg <= '0;
            end
            else if (accept)
            begin
                epoch_reg <= in_epoch;
            end
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_reg.vertex <= in_vertex;
            b_reg.stored <= int'(in_vertex) < MAX_VERTICES;
            b_reg.last   <= s_axis_tlast;
            b_reg.fresh  <= in_fresh;
            b_reg.epoch  <= in_epoch;
            b_nb_reg     <= in_nb;
            b_nb_ok_reg  <= in_has && (int'(in_nb) < MAX_VERTICES);
        end
        if (adv)
        begin
            c_reg      <= b_reg;
            c_mask_reg <= fin_mask;
            d_reg      <= c_reg;
            d_free_reg <= c_free;
            d_off_reg  <= c_off;
        end
        if (d_wr)
        begin
            lw_vertex_reg <= d_reg.vertex;
            lw_epoch_reg  <= d_reg.epoch;
            lw_color_reg  <= d_color;
        end
        if (out_load)
        begin
            out_vertex_reg <= d_reg.vertex;
            out_color_reg  <= d_color;
            out_count_reg  <= d_count_new;
            out_ovf_reg    <= d_ovf;
        end
    end

    // result port
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, OCOUNT_W'(out_count_reg),
                            OCOLOR_W'(out_color_reg), out_vertex_reg};
    assign m_axis_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    // color count never passes the palette
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_COLORS))
        else $error("color count beyond palette size");

    // a reported color is always below the reported count
    a_color_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> CNT_W'(out_color_reg) < out_count_reg)
        else $error("assigned color not below colors used");

    // overflow only with a full palette
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && out_ovf_reg |-> out_count_reg == CNT_W'(MAX_COLORS))
        else $error("overflow reported with palette not full");

    // sweep owns the ram write port alone
    a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> pipe_empty && !accept)
        else $error("pipeline busy during ram sweep");
`endif

endmodule

>>> sv/gffgc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module gffgc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port, read port returns the old value on a same-cycle collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> tb/gffgc_color_checker.sv
// color predictor and result checker for the greedy first-fit graph coloring block
`timescale 1ns / 1ps

module gffgc_color_checker
    import gffgc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // [11:0] vertex_id, [23:12] neighbor_id
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] has_neighbor, [1] new_graph
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    input  logic                 s_axis_tlast,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [11:0] colored_vertex, [19:12] assigned_color, [28:20] colors_used, zero above
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] palette_overflow
    input  logic                 m_axis_tuser,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        vid_t                vertex;
        logic [OCOLOR_W-1:0] color;
        logic [OCOUNT_W-1:0] count;
        logic                ovf;
    } color_result_t;

    // predicted coloring state
    logic [OCOLOR_W-1:0]        color_mem [DEF_MAX_VERTICES];
    bit [DEF_MAX_VERTICES-1:0]  colored;
    bit [DEF_MAX_COLORS-1:0]    forbid;
    int unsigned                num_colors;

    color_result_t              expected_colors [$];
    int                         err_cnt;

    // apply one request to the predicted state, queue a result on a close
    function automatic void color_request(vid_t v, vid_t w, logic has_n, logic last,
                                          logic fresh);
        int unsigned   c;
        int unsigned   k;
        bit            found;
        logic          ovf;
        color_result_t r;
        if (fresh)
        begin
            colored    = '0;
            forbid     = '0;
            num_colors = 0;
        end
        if (has_n && colored[w])
            forbid[color_mem[w]] = 1'b1;
        if (!last)
            return;
        c     = 0;
        k     = 0;
        found = 1'b0;
        ovf   = 1'b0;
        // lowest allocated color not seen among the row
        while (!found && k < num_colors)
        begin
            if (!forbid[k])
            begin
                c     = k;
                found = 1'b1;
            end
            else
                k++;
        end
        if (!found)
        begin
            if (num_colors < DEF_MAX_COLORS)
            begin
                c = num_colors;
                num_colors++;
            end
            else
            begin
                // palette full: saturate on the top color
                c   = DEF_MAX_COLORS - 1;
                ovf = 1'b1;
            end
        end
        color_mem[v] = c[OCOLOR_W-1:0];
        colored[v]   = 1'b1;
        forbid       = '0;
        r.vertex = v;
        r.color  = c[OCOLOR_W-1:0];
        r.count  = num_colors[OCOUNT_W-1:0];
        r.ovf    = ovf;
        expected_colors.push_back(r);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // follow both channels, predict on each request, compare each result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colored    = '0;
            forbid     = '0;
            num_colors = 0;
            expected_colors.delete();
            err_cnt    = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                color_request(s_axis_tdata[VID_W-1:0], s_axis_tdata[VID_W +: VID_W],
                              s_axis_tuser[USER_HAS], s_axis_tlast, s_axis_tuser[USER_NEW]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: result expected none got tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    err_cnt++;
                end
                else
                begin
                    color_result_t want;
                    want = expected_colors.pop_front();
                    check_field("colored_vertex", 32'(want.vertex),
                                32'(m_axis_tdata[VID_W-1:0]));
                    check_field("assigned_color", 32'(want.color),
                                32'(m_axis_tdata[VID_W +: OCOLOR_W]));
                    check_field("colors_used", 32'(want.count),
                                32'(m_axis_tdata[VID_W+OCOLOR_W +: OCOUNT_W]));
                    check_field("tdata padding", 32'd0,
                                32'(m_axis_tdata[M_TDATA_W-1 -: M_PAD_W]));
                    check_field("palette_overflow", 32'(want.ovf), 32'(m_axis_tuser));
                end
            end
            errors  <= err_cnt;
            pending <= expected_colors.size();
        end
    end

endmodule

>>> tb/greedy_first_fit_graph_coloring_tb.sv
// stimulus and verdict for the greedy first-fit graph coloring block
`timescale 1ns / 1ps

module greedy_first_fit_graph_coloring_tb;
    import gffgc_pkg::*;

    // a full color-ram sweep has no handshake, the limit allows several sweeps
    localparam int QUIET_LIMIT = 20000;
    localparam int PHASE_ITEMS = 280;
    localparam int CLIQUE_N    = 40;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // [11:0] vertex_id, [23:12] neighbor_id
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // [0] has_neighbor, [1] new_graph
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [11:0] colored_vertex, [19:12] assigned_color, [28:20] colors_used, zero above
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [0] palette_overflow
    logic                 m_axis_tuser;

    int                   errors;
    int                   pending;
    int                   send_idle = 0;
    int                   recv_stall = 0;
    int                   quiet_cycles = 0;
    vid_t                 colored_ids [$];

    greedy_first_fit_graph_coloring uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gffgc_color_checker u_color_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending)
    );

    // clock
    always #10 clk = ~clk;

    // result side back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall);

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("greedy_first_fit_graph_coloring_tb: done, errors");
            $finish;
        end
    end

    // one request, with random idle cycles ahead of it
    task automatic send_req(vid_t vid, vid_t nid, bit has_n, bit last, bit newg);
        logic [S_TUSER_W-1:0] flags;
        flags           = '0;
        flags[USER_HAS] = has_n;
        flags[USER_NEW] = newg;
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nid, vid};
        s_axis_tuser  <= flags;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (newg)
            colored_ids.delete();
        if (last)
            colored_ids.push_back(vid);
    endtask

    // hold off the sender until every result is out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic vid_t pick_vertex();
        int unsigned r;
        r = $urandom_range(99);
        if (colored_ids.size() > 0 && r < 10)
            return colored_ids[$urandom_range(colored_ids.size() - 1)];
        else if (r < 20)
            return vid_t'($urandom_range(15));
        return vid_t'($urandom);
    endfunction

    function automatic vid_t pick_neighbor(vid_t self_id);
        int unsigned r;
        r = $urandom_range(99);
        if (colored_ids.size() > 0 && r < 75)
            return colored_ids[$urandom_range(colored_ids.size() - 1)];
        else if (r < 85)
            return self_id;
        return vid_t'($urandom);
    endfunction

    // short hand-picked sequence over the corner cases
    task automatic run_directed();
        // empty row opening a graph, then extreme ids
        send_req(12'd0, 12'd0, 1'b0, 1'b1, 1'b1);
        send_req(12'd4095, 12'd0, 1'b1, 1'b1, 1'b0);
        send_req(12'd1, 12'd0, 1'b1, 1'b0, 1'b0);
        send_req(12'd1, 12'd4095, 1'b1, 1'b1, 1'b0);
        // uncolored neighbor
        send_req(12'd2, 12'd3000, 1'b1, 1'b1, 1'b0);
        // self neighbor, recolor
        send_req(12'd4095, 12'd4095, 1'b1, 1'b1, 1'b0);
        // vertex changing mid-row
        send_req(12'd100, 12'd0, 1'b1, 1'b0, 1'b0);
        send_req(12'd200, 12'd1, 1'b1, 1'b1, 1'b0);
        // neither neighbor nor close
        send_req(12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0);
        // new graph clears before its own neighbor
        send_req(12'd3, 12'd0, 1'b1, 1'b0, 1'b1);
        send_req(12'd5, 12'd0, 1'b0, 1'b1, 1'b0);
        send_req(12'd7, 12'd5, 1'b1, 1'b1, 1'b1);
        // neighbor closed one and two requests earlier
        send_req(12'd8, 12'd0, 1'b0, 1'b1, 1'b0);
        send_req(12'd9, 12'd8, 1'b1, 1'b1, 1'b0);
        send_req(12'd10, 12'd8, 1'b1, 1'b1, 1'b0);
        send_req(12'd11, 12'd9, 1'b1, 1'b1, 1'b0);
        send_req(12'd12, 12'd0, 1'b0, 1'b1, 1'b0);
        send_req(12'd13, 12'd11, 1'b1, 1'b1, 1'b0);
        send_req(12'd13, 12'd12, 1'b1, 1'b0, 1'b0);
        send_req(12'd14, 12'd13, 1'b1, 1'b1, 1'b0);
    endtask

    // many new-graph requests in a row to walk the generation tag through a wrap
    task automatic run_new_graph_burst();
        int i;
        for (i = 0; i < 70; i++)
            send_req(vid_t'(i), vid_t'($urandom), 1'b0, (i % 8) == 0, 1'b1);
    endtask

    // clique over CLIQUE_N vertices, every vertex needs a new color
    task automatic run_clique();
        int k;
        int j;
        send_req(12'd0, 12'd0, 1'b0, 1'b1, 1'b1);
        for (k = 1; k < CLIQUE_N; k++)
        begin
            for (j = 0; j < k; j++)
                send_req(vid_t'(k), vid_t'(j), 1'b1, j == k - 1, 1'b0);
        end
        // a free color below the count
        for (j = 0; j < 10; j++)
            send_req(12'd300, vid_t'(j), 1'b1, j == 9, 1'b0);
        send_req(12'd301, vid_t'(CLIQUE_N - 2), 1'b1, 1'b0, 1'b0);
        send_req(12'd301, vid_t'(CLIQUE_N - 1), 1'b1, 1'b1, 1'b0);
    endtask

    // random rows, mostly well formed
    task automatic run_random(int target);
        int   n;
        int   kind;
        int   len;
        int   j;
        vid_t v;
        bit   newg;
        n = 0;
        while (n < target)
        begin
            kind = $urandom_range(99);
            newg = ($urandom_range(39) == 0);
            v    = pick_vertex();
            if (kind < 80)
            begin
                len = $urandom_range(7);
                if (len == 0)
                begin
                    send_req(v, vid_t'($urandom), 1'b0, 1'b1, newg);
                    n++;
                end
                else
                begin
                    for (j = 0; j < len; j++)
                    begin
                        send_req(v, pick_neighbor(v), 1'b1, j == len - 1, newg && j == 0);
                        n++;
                    end
                end
            end
            else if (kind < 88)
            begin
                // vertex id wandering within one row
                len = $urandom_range(5, 2);
                for (j = 0; j < len; j++)
                begin
                    send_req(pick_vertex(), pick_neighbor(v), $urandom_range(3) != 0,
                             j == len - 1, newg && j == 0);
                    n++;
                end
            end
            else if (kind < 94)
                send_req(v, vid_t'($urandom), 1'b0, 1'b0, newg);
            else
            begin
                // open row left hanging, its mask runs into the next row
                send_req(v, pick_neighbor(v), 1'b1, 1'b0, newg);
                n++;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain_results();

        send_idle  <= 9;
        recv_stall <= 9;
        run_new_graph_burst();

        send_idle  <= 0;
        recv_stall <= 0;
        run_clique();

        run_random(PHASE_ITEMS);
        send_idle <= 46;
        run_random(PHASE_ITEMS);
        drain_results();
        send_idle  <= 0;
        recv_stall <= 46;
        run_random(PHASE_ITEMS);
        send_idle  <= 9;
        recv_stall <= 9;
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("greedy_first_fit_graph_coloring_tb: done, clean");
        else
            $display("greedy_first_fit_graph_coloring_tb: done, errors");
        $finish;
    end

endmodule

>>> files.f
sv/gffgc_pkg.sv
sv/gffgc_ram.sv
sv/greedy_first_fit_graph_coloring.sv
tb/gffgc_color_checker.sv
tb/greedy_first_fit_graph_coloring_tb.sv
